/* rtl/fmqd_pkg.sv */
// Shared types and constants of the FM quadrature discriminator.
package fmqd_pkg;

  // Field widths of the channels and the register file
  localparam int SAMPLE_W = 8;
  localparam int DECIM_W  = 8;
  localparam int GAIN_W   = 24;
  localparam int AUDIO_W  = 16;

  // Internal arithmetic widths: products of centred bytes, |numerator|, denominator
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int MAG_W  = 16;
  localparam int DEN_W  = 16;
  localparam int QUO_W  = 16;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port layout
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_IN_DECIM  = 2'd0;
  localparam logic [1:0] REG_OUT_DECIM = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;

  // Register reset values
  localparam logic [DECIM_W-1:0] IN_DECIM_RST  = 8'd1;
  localparam logic [DECIM_W-1:0] OUT_DECIM_RST = 8'd1;
  localparam logic [GAIN_W-1:0]  GAIN_RST      = 24'd256;

  // Saturation limits of the audio word
  localparam logic signed [AUDIO_W-1:0] AUDIO_MAX = 16'sh7FFF;
  localparam logic signed [AUDIO_W-1:0] AUDIO_MIN = 16'sh8000;

  // Decimation settings seen by the front
  typedef struct packed {
    logic [DECIM_W-1:0] in_decim;
    logic [DECIM_W-1:0] out_decim;
  } decim_cfg_t;

  // One discriminator job: current and previous kept pair, midpoint removed
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ci;
    logic signed [SAMPLE_W-1:0] cq;
    logic signed [SAMPLE_W-1:0] pi;
    logic signed [SAMPLE_W-1:0] pq;
  } job_t;

  // Queue handshake towards the front
  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  // Queue status towards the back
  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

endpackage

/* rtl/fmqd_in_if.sv */
// Input channel: one offset-binary I/Q pair per beat.
interface fmqd_in_if
  import fmqd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_i;
  logic [SAMPLE_W-1:0] sample_q;
  logic                block_start;

  modport source (output valid, output sample_i, output sample_q, output block_start,
                  input ready);
  modport sink   (input valid, input sample_i, input sample_q, input block_start,
                  output ready);
endinterface

/* rtl/fmqd_out_if.sv */
// Result channel: one signed audio sample per beat.
interface fmqd_out_if
  import fmqd_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [AUDIO_W-1:0]  audio;

  modport source (output valid, output audio, input ready);
  modport sink   (input valid, input audio, output ready);
endinterface

/* rtl/fmqd_front.sv */
// Front end: accepts I/Q beats, applies decimation and history, and issues jobs.
module fmqd_front
  import fmqd_pkg::*;
  (
  input  logic        clk,
  input  logic        rst_n,
  fmqd_in_if.sink     in_chan,
  input  decim_cfg_t  cfg,
  input  logic        q_full,
  output q_wr_t       q_wr
);

  logic [SAMPLE_W-1:0] prev_i_r, prev_q_r;
  logic                have_prev_r;
  logic [DECIM_W-1:0]  in_count_r, out_count_r;

  logic                accept;
  logic                hp;
  logic [DECIM_W-1:0]  ic, oc, idec, odec;
  logic [DECIM_W:0]    ic_inc, oc_inc;
  logic                keep;
  logic [DECIM_W-1:0]  in_count_nxt, out_count_nxt;

  // A beat is taken whenever the queue can hold a job
  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  // A block start clears history and both counters before the pair is handled
  always_comb begin
    hp   = in_chan.block_start ? 1'b0 : have_prev_r;
    ic   = in_chan.block_start ? '0 : in_count_r;
    oc   = in_chan.block_start ? '0 : out_count_r;
    idec = (cfg.in_decim == '0) ? DECIM_W'(1) : cfg.in_decim;
    odec = (cfg.out_decim == '0) ? DECIM_W'(1) : cfg.out_decim;
    ic_inc = {1'b0, ic} + (DECIM_W+1)'(1);
    oc_inc = {1'b0, oc} + (DECIM_W+1)'(1);
    keep = (ic == '0);
    in_count_nxt  = (ic_inc >= {1'b0, idec}) ? '0 : ic_inc[DECIM_W-1:0];
    out_count_nxt = (keep && hp) ?
                    ((oc_inc >= {1'b0, odec}) ? '0 : oc_inc[DECIM_W-1:0]) : oc;
  end

  // Only a kept pair with history whose value survives output decimation becomes a job
  always_comb begin
    q_wr.push   = accept && keep && hp && (oc == '0);
    q_wr.job.ci = signed'({~in_chan.sample_i[SAMPLE_W-1], in_chan.sample_i[SAMPLE_W-2:0]});
    q_wr.job.cq = signed'({~in_chan.sample_q[SAMPLE_W-1], in_chan.sample_q[SAMPLE_W-2:0]});
    q_wr.job.pi = signed'({~prev_i_r[SAMPLE_W-1], prev_i_r[SAMPLE_W-2:0]});
    q_wr.job.pq = signed'({~prev_q_r[SAMPLE_W-1], prev_q_r[SAMPLE_W-2:0]});
  end

  // History and decimation counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_i_r    <= '0;
      prev_q_r    <= '0;
      have_prev_r <= 1'b0;
      in_count_r  <= '0;
      out_count_r <= '0;
    end else if (accept) begin
      in_count_r  <= in_count_nxt;
      out_count_r <= out_count_nxt;
      have_prev_r <= hp || keep;
      if (keep) begin
        prev_i_r <= in_chan.sample_i;
        prev_q_r <= in_chan.sample_q;
      end
    end
  end

endmodule

/* rtl/fmqd_queue.sv */
// Short job queue that decouples the front from the arithmetic back end.
module fmqd_queue
  import fmqd_pkg::*;
  (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  full,
  input  logic  pop,
  output q_rd_t q_rd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.job   = mem_r[rd_ptr_r];

  // Storage for the queued jobs
  always_ff @(posedge clk) begin
    if (q_wr.push && !full) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

  // Pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop && q_rd.valid) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({q_wr.push && !full, pop && q_rd.valid})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/fmqd_back.sv */
// Back end: products, scaled restoring division, saturation and the output register.
module fmqd_back
  import fmqd_pkg::*;
  #(
  parameter int GAIN_FRAC_BITS = 8
  ) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_rd_t             q_rd,
  output logic              q_pop,
  input  logic [GAIN_W-1:0] gain,
  fmqd_out_if.source        out_chan
);

  localparam int PW    = MAG_W + GAIN_W;
  localparam int DW    = DEN_W + GAIN_FRAC_BITS + QUO_W;
  localparam int RW    = (PW > DW) ? PW : DW;
  localparam int CNT_W = $clog2(QUO_W);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PROD = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_CHK  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  job_t                      job_r;
  logic signed [PROD_W-1:0]  p1_r, p2_r, s1_r, s2_r;
  logic                      neg_r, zero_r, ovf_r;
  logic [MAG_W-1:0]          mag_r;
  logic [DEN_W-1:0]          den_r;
  logic [RW-1:0]             rem_r, dsh_r;
  logic [QUO_W-1:0]          quo_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      out_valid_r;
  logic signed [AUDIO_W-1:0] audio_r;

  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          num_abs;
  logic [PW-1:0]             prod;
  logic                      ge;
  logic                      slot_free;
  logic                      big;
  logic signed [AUDIO_W-1:0] result;

  assign q_pop          = (state_r == ST_IDLE) && q_rd.valid;
  assign slot_free      = !out_valid_r || out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.audio = audio_r;

  // Datapath helpers for the current step
  always_comb begin
    num     = NUM_W'(p1_r) - NUM_W'(p2_r);
    num_abs = num[NUM_W-1] ? -num : num;
    prod    = PW'(mag_r) * PW'(gain);
    ge      = (rem_r >= dsh_r);
    big     = ovf_r || quo_r[QUO_W-1];
    if (zero_r) begin
      result = '0;
    end else if (neg_r) begin
      result = big ? AUDIO_MIN : -signed'(quo_r);
    end else begin
      result = big ? AUDIO_MAX : signed'(quo_r);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_rd.valid) state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_CHK;
      ST_CHK: begin
        state_nxt = (zero_r || (rem_r >= (dsh_r << 1))) ? ST_DONE : ST_DIV;
      end
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_DONE;
      ST_DONE: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Arithmetic registers: num = cq*pi - ci*pq, den = ci^2 + cq^2
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        job_r <= q_rd.job;
      end
      ST_PROD: begin
        p1_r <= job_r.cq * job_r.pi;
        p2_r <= job_r.ci * job_r.pq;
        s1_r <= job_r.ci * job_r.ci;
        s2_r <= job_r.cq * job_r.cq;
      end
      ST_SUM: begin
        neg_r  <= num[NUM_W-1];
        mag_r  <= num_abs[MAG_W-1:0];
        den_r  <= DEN_W'(s1_r[PROD_W-2:0]) + DEN_W'(s2_r[PROD_W-2:0]);
        zero_r <= (s1_r == '0) && (s2_r == '0);
      end
      ST_MUL: begin
        rem_r <= RW'(prod);
        dsh_r <= RW'(den_r) << (GAIN_FRAC_BITS + QUO_W - 1);
      end
      ST_CHK: begin
        ovf_r <= (rem_r >= (dsh_r << 1));
        quo_r <= '0;
        cnt_r <= CNT_W'(QUO_W - 1);
      end
      ST_DIV: begin
        // One quotient bit per cycle
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[QUO_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      default: begin
        job_r <= job_r;
      end
    endcase
  end

  // Output register, loaded once the previous sample has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && slot_free) begin
      audio_r <= result;
    end
  end

endmodule

/* rtl/fm_quadrature_discriminator.sv */
// FM quadrature discriminator: I/Q beats in, decimated and scaled audio beats out.
//
// The input channel carries one offset-binary I/Q pair per beat, with a block
// start flag that clears the pair history and both decimation counters. The
// output channel carries one saturated signed audio sample per beat. An APB
// port holds the input decimation, output decimation and Q16.8 gain registers.
// Beats that give no audio sample are taken without forming a job. A beat that
// gives a sample becomes a job in a two-entry queue; the back end runs each job
// through its product, sum, gain multiply and check steps and then through the
// one-bit-per-cycle restoring divider, which a zero denominator or an overflowed
// quotient skips. The back end takes a new job from the queue only once it has
// handed the last one to the output register. The input is held off only while
// the queue is full. Reset clears history, counters, queue and output register
// and loads the registers with decimation 1 and unity gain. A stall on the
// output holds the finished sample in its register while the next job is
// already computed.
module fm_quadrature_discriminator
  import fmqd_pkg::*;
  #(
  parameter int GAIN_FRAC_BITS = 8
  ) (
  input  logic               clk,
  input  logic               rst_n,
  fmqd_in_if.sink            in_chan,
  fmqd_out_if.source         out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [DECIM_W-1:0] in_decim_r, out_decim_r;
  logic [GAIN_W-1:0]  gain_r;
  logic               cfg_wr;
  decim_cfg_t         decim_cfg;
  q_wr_t              q_wr;
  q_rd_t              q_rd;
  logic               q_full;
  logic               q_pop;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_decim_r  <= IN_DECIM_RST;
      out_decim_r <= OUT_DECIM_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_IN_DECIM:  in_decim_r  <= pwdata[DECIM_W-1:0];
        REG_OUT_DECIM: out_decim_r <= pwdata[DECIM_W-1:0];
        REG_GAIN:      gain_r      <= pwdata[GAIN_W-1:0];
        default:       gain_r      <= gain_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IN_DECIM:  prdata = PDATA_W'(in_decim_r);
      REG_OUT_DECIM: prdata = PDATA_W'(out_decim_r);
      REG_GAIN:      prdata = PDATA_W'(gain_r);
      default:       prdata = '0;
    endcase
  end

  assign decim_cfg.in_decim  = in_decim_r;
  assign decim_cfg.out_decim = out_decim_r;

  // Front end, queue and back end
  fmqd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (decim_cfg),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  fmqd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .q_rd  (q_rd)
  );

  fmqd_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rd     (q_rd),
    .q_pop    (q_pop),
    .gain     (gain_r),
    .out_chan (out_chan)
  );

`ifndef SYNTH
  // The front never issues a job into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && q_full))
    else $error("job issued into a full queue");

  // The back end only takes a job that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("queue popped while empty");

  // A job pushed into an empty queue is visible to the back end next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.push && !q_rd.valid) |=> q_rd.valid)
    else $error("pushed job lost");
`endif

endmodule
